// File: hw/rtl/htfc_pkg.sv
// Package for the humidity/temperature frame checker.
// Holds the status codes, the CRC-8 step and the frame result type.
// No dependencies.
`timescale 1ns / 1ps

package htfc_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [2:0] LAST_POS = 3'd5;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FIRST_BAD  = 2'd1,
    STATUS_SECOND_BAD = 2'd2,
    STATUS_SHORT      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    POS_WORD1_HI = 3'd0,
    POS_WORD1_LO = 3'd1,
    POS_CRC1     = 3'd2,
    POS_WORD2_HI = 3'd3,
    POS_WORD2_LO = 3'd4,
    POS_CRC2     = 3'd5
  } pos_t;

  // Result of one accepted item, handed from the frame tracker to the output stage.
  typedef struct packed {
    logic        valid;
    status_t     status;
    logic        short_read;
    logic [15:0] first_word;
    logic [15:0] second_word;
  } frame_res_t;

  // CRC-8, polynomial 0x31, MSB first, over one byte.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/htfc_frame.sv
// Frame tracker: byte position, running CRC, word capture and status.
// Depends on htfc_pkg.
`timescale 1ns / 1ps

module htfc_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic                cmd,
  input  logic [7:0]          data_byte,
  output htfc_pkg::frame_res_t res
);

  logic [2:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] word_one_r, word_one_nxt;
  logic [15:0] word_two_r, word_two_nxt;
  logic        first_bad_r, first_bad_nxt;
  logic [2:0]  pos;
  logic [7:0]  crc_step;
  logic        second_bad;

  // Out-of-range count restarts the frame.
  assign pos      = (byte_count_r > htfc_pkg::LAST_POS) ? 3'd0 : byte_count_r;
  assign crc_step = htfc_pkg::crc8_byte(crc_r, data_byte);
  assign second_bad = (data_byte != crc_r);

  always_comb begin
    byte_count_nxt = byte_count_r;
    crc_nxt        = crc_r;
    word_one_nxt   = word_one_r;
    word_two_nxt   = word_two_r;
    first_bad_nxt  = first_bad_r;
    res.valid       = 1'b0;
    res.status      = htfc_pkg::STATUS_OK;
    res.short_read  = 1'b0;
    res.first_word  = word_one_r;
    res.second_word = word_two_r;
    if (acc) begin
      if (cmd) begin
        if (byte_count_r != 3'd0) begin
          res.valid       = 1'b1;
          res.status      = htfc_pkg::STATUS_SHORT;
          res.short_read  = 1'b1;
          res.first_word  = 16'd0;
          res.second_word = 16'd0;
          byte_count_nxt  = 3'd0;
          crc_nxt         = htfc_pkg::CRC_INIT;
          word_one_nxt    = 16'd0;
          word_two_nxt    = 16'd0;
          first_bad_nxt   = 1'b0;
        end
      end else begin
        byte_count_nxt = pos + 3'd1;
        unique case (pos)
          htfc_pkg::POS_WORD1_HI: begin
            word_one_nxt = {data_byte, 8'd0};
            crc_nxt      = crc_step;
          end
          htfc_pkg::POS_WORD1_LO: begin
            word_one_nxt = {word_one_r[15:8], data_byte};
            crc_nxt      = crc_step;
          end
          htfc_pkg::POS_CRC1: begin
            first_bad_nxt = (data_byte != crc_r);
            crc_nxt       = htfc_pkg::CRC_INIT;
          end
          htfc_pkg::POS_WORD2_HI: begin
            word_two_nxt = {data_byte, 8'd0};
            crc_nxt      = crc_step;
          end
          htfc_pkg::POS_WORD2_LO: begin
            word_two_nxt = {word_two_r[15:8], data_byte};
            crc_nxt      = crc_step;
          end
          default: begin
            res.valid = 1'b1;
            if (first_bad_r) begin
              res.status = htfc_pkg::STATUS_FIRST_BAD;
            end else if (second_bad) begin
              res.status = htfc_pkg::STATUS_SECOND_BAD;
            end else begin
              res.status = htfc_pkg::STATUS_OK;
            end
            byte_count_nxt = 3'd0;
            crc_nxt        = htfc_pkg::CRC_INIT;
            word_one_nxt   = 16'd0;
            word_two_nxt   = 16'd0;
            first_bad_nxt  = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= 3'd0;
      crc_r        <= htfc_pkg::CRC_INIT;
      word_one_r   <= 16'd0;
      word_two_r   <= 16'd0;
      first_bad_r  <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      crc_r        <= crc_nxt;
      word_one_r   <= word_one_nxt;
      word_two_r   <= word_two_nxt;
      first_bad_r  <= first_bad_nxt;
    end
  end

endmodule

// File: hw/rtl/htfc_scale.sv
// Scaling of the raw words to centidegrees and centipercent.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module htfc_scale (
  input  logic               zero,
  input  logic [15:0]        first_word,
  input  logic [15:0]        second_word,
  output logic signed [14:0] temperature_centi,
  output logic signed [14:0] humidity_centi
);

  localparam logic [12:0] TEMP_GAIN = 13'd4375;
  localparam logic [11:0] HUM_GAIN  = 12'd3125;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;
  localparam logic signed [15:0] HUM_OFFSET  = 16'sd600;

  logic [28:0]        temp_prod;
  logic [27:0]        hum_prod;
  logic signed [15:0] temp_full;
  logic signed [15:0] hum_full;

  assign temp_prod = TEMP_GAIN * first_word;
  assign hum_prod  = HUM_GAIN * second_word;
  // Drop 14 fraction bits, then remove the offset in signed form.
  assign temp_full = $signed({1'b0, temp_prod[28:14]}) - TEMP_OFFSET;
  assign hum_full  = $signed({2'b00, hum_prod[27:14]}) - HUM_OFFSET;

  assign temperature_centi = zero ? 15'sd0 : temp_full[14:0];
  assign humidity_centi    = zero ? 15'sd0 : hum_full[14:0];

endmodule

// File: hw/rtl/humidity_temp_frame_checker_core.sv
// Top level of the humidity/temperature frame checker.
// Depends on htfc_pkg, htfc_frame and htfc_scale.
//
// Usage:
//   Input channel in_valid/in_ready carries one item per handshake: in_cmd 0
//   delivers a response byte on in_data_byte, in_cmd 1 marks end of transfer.
//   After the sixth byte of a frame one result item appears on the out_
//   channel with status (ok, first CRC bad, second CRC bad, short read), the
//   raw words, the serial number and the scaled readings. An end marker after
//   one to five bytes gives a short-read item with all other fields zero; an
//   end marker with no bytes pending gives nothing.
//   A result is valid on the cycle after the sixth byte is taken.
//   Throughput: one item per cycle while in_ready is high; the CRC step,
//   the frame update and the scaling multipliers all complete between the
//   input handshake and the single output register.
//   Reset (rst_n low, synchronous): frame state clears, no result is valid.
//   Receiver stall: the output register holds its item; in_ready drops only
//   while that register is full and out_ready is low.
`timescale 1ns / 1ps

module humidity_temp_frame_checker_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [15:0]        out_first_word,
  output logic [15:0]        out_second_word,
  output logic [31:0]        out_serial_number,
  output logic signed [14:0] out_temperature_centi,
  output logic signed [14:0] out_humidity_centi
);

  htfc_pkg::frame_res_t res;
  logic                 in_acc;
  logic signed [14:0]   temp_c;
  logic signed [14:0]   hum_c;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         status_r;
  logic [15:0]        first_word_r;
  logic [15:0]        second_word_r;
  logic signed [14:0] temp_r;
  logic signed [14:0] hum_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  htfc_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .cmd       (in_cmd),
    .data_byte (in_data_byte),
    .res       (res)
  );

  htfc_scale u_scale (
    .zero              (res.short_read),
    .first_word        (res.first_word),
    .second_word       (res.second_word),
    .temperature_centi (temp_c),
    .humidity_centi    (hum_c)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load payload only when a new result is produced.
  always_ff @(posedge clk) begin
    if (res.valid) begin
      status_r      <= res.status;
      first_word_r  <= res.first_word;
      second_word_r <= res.second_word;
      temp_r        <= temp_c;
      hum_r         <= hum_c;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = status_r;
  assign out_first_word        = first_word_r;
  assign out_second_word       = second_word_r;
  assign out_serial_number     = {first_word_r, second_word_r};
  assign out_temperature_centi = temp_r;
  assign out_humidity_centi    = hum_r;

`ifndef NO_ASSERTIONS
  a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> out_valid_r)
    else $error("produced result did not reach the output register");

  a_res_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (!out_valid_r || out_ready))
    else $error("result produced while the output register was full");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status == htfc_pkg::STATUS_SHORT) |->
      (out_first_word == 16'd0 && out_second_word == 16'd0 &&
       out_temperature_centi == 15'sd0 && out_humidity_centi == 15'sd0))
    else $error("short-read item carries nonzero fields");
`endif

endmodule
